[rtl/lkvc_pkg.sv]
// Shared constants for the LRU key-value cache.
package lkvc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int RANK_W  = IDX_W;
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 5;
   localparam int CAP_RST = 16;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

endpackage

[rtl/lru_key_value_cache.sv]
// Fully associative key-value cache with least-recently-used replacement.
//
// Channel   Dir   Handshake              Payload
// req_      in    req_tvalid/req_tready  tuser: func; tdata: key, value
// rsp_      out   rsp_tvalid/rsp_tready  tuser: hit, evicted; tdata: read_value, evicted_key
// csr_      in    csr_wr_en              csr_wr_data: capacity_in_use
//
// A request scans every slot through the single read port of the key/value memory with
// one comparator, then the update state writes the store and loads the response register.
// req_tready stays low from acceptance until the response is taken, so a stalled rsp_tready
// holds off requests. reset is synchronous: it clears the valid bits, the occupancy count
// and the sequencer and loads capacity 16.
module lru_key_value_cache (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,      // [0] func
   input  logic [63:0]  req_tdata,      // [31:0] key, [63:32] value
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,      // [0] hit, [1] evicted
   output logic [63:0]  rsp_tdata,      // [31:0] read_value, [63:32] evicted_key
   input  logic         csr_wr_en,
   input  logic [4:0]   csr_wr_data     // [4:0] capacity_in_use
);

   localparam int IDX_W  = lkvc_pkg::IDX_W;
   localparam int CNT_W  = lkvc_pkg::CNT_W;
   localparam int RANK_W = lkvc_pkg::RANK_W;
   localparam int DATA_W = lkvc_pkg::DATA_W;
   localparam int N      = lkvc_pkg::ENTRIES;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   // sequencer and request latch
   logic [1:0]              state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    func_ff;
   logic [DATA_W-1:0]       key_ff, val_ff;
   logic [lkvc_pkg::CAP_W-1:0] cap_ff;

   // store
   logic [DATA_W-1:0]       key_mem [N];
   logic [DATA_W-1:0]       val_mem [N];
   logic [RANK_W-1:0]       rank_ff [N];
   logic [N-1:0]            valid_ff;
   logic [CNT_W-1:0]        occ_ff;

   // scan read stage
   logic                    rd_pend_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic [DATA_W-1:0]       rd_key_ff, rd_val_ff;
   logic [IDX_W-1:0]        scan_addr;

   // scan findings
   logic                    found_ff, vict_ok_ff, free_ok_ff;
   logic [IDX_W-1:0]        found_idx_ff, vict_idx_ff, free_idx_ff;
   logic [RANK_W-1:0]       found_rank_ff;
   logic [DATA_W-1:0]       found_val_ff, vict_key_ff;

   // response register
   logic                    rsp_valid_ff;
   logic                    rsp_hit_ff, rsp_evict_ff;
   logic [DATA_W-1:0]       rsp_rval_ff, rsp_ekey_ff;

   // update decode
   logic [CNT_W-1:0]        eff_cap;
   logic                    do_evict, do_fill, do_promote;
   logic [IDX_W-1:0]        tgt_idx;
   logic [RANK_W-1:0]       old_rank, lru_rank;
   logic                    slot_valid, key_match;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_evict_ff, rsp_hit_ff};
   assign rsp_tdata  = {rsp_ekey_ff, rsp_rval_ff};

   assign scan_addr  = cnt_ff[IDX_W-1:0];
   assign lru_rank   = RANK_W'(occ_ff - CNT_W'(1));
   assign slot_valid = valid_ff[rd_idx_ff];
   assign key_match  = rd_pend_ff && slot_valid && (rd_key_ff == key_ff);

   // capacity clamp: zero acts as one, above the slot count saturates
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (32'(cap_ff) > 32'(N)) begin
         eff_cap = CNT_W'(N);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   // what the put/get does once the scan is over
   always_comb begin
      do_evict   = (func_ff == lkvc_pkg::FUNC_PUT) && !found_ff && (occ_ff >= eff_cap)
                   && vict_ok_ff;
      do_fill    = (func_ff == lkvc_pkg::FUNC_PUT) && !found_ff && !do_evict && free_ok_ff;
      do_promote = found_ff || do_evict || do_fill;
      if (found_ff) begin
         tgt_idx  = found_idx_ff;
         old_rank = found_rank_ff;
      end else if (do_evict) begin
         tgt_idx  = vict_idx_ff;
         old_rank = lru_rank;
      end else begin
         tgt_idx  = free_idx_ff;
         old_rank = lru_rank;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(N)) begin
               state_in = ST_UPD;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_UPD: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         cap_ff   <= lkvc_pkg::CAP_W'(lkvc_pkg::CAP_RST);
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         func_ff <= req_tuser;
         key_ff  <= req_tdata[31:0];
         val_ff  <= req_tdata[63:32];
      end
   end

   // key/value memory: one read a cycle during the scan, one write at update
   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[scan_addr];
      rd_val_ff <= val_mem[scan_addr];
      if (state_ff == ST_UPD) begin
         if (do_evict || do_fill) begin
            key_mem[tgt_idx] <= key_ff;
         end
         if (do_promote && (func_ff == lkvc_pkg::FUNC_PUT)) begin
            val_mem[tgt_idx] <= val_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= (state_ff == ST_SCAN) && (cnt_ff != CNT_W'(N));
      end
      rd_idx_ff <= scan_addr;
   end

   // scan bookkeeping: first key match, the LRU slot, first free slot
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         found_ff   <= 1'b0;
         vict_ok_ff <= 1'b0;
         free_ok_ff <= 1'b0;
      end else if ((state_ff == ST_SCAN) && rd_pend_ff) begin
         if (key_match && !found_ff) begin
            found_ff      <= 1'b1;
            found_idx_ff  <= rd_idx_ff;
            found_rank_ff <= rank_ff[rd_idx_ff];
            found_val_ff  <= rd_val_ff;
         end
         if (slot_valid && (rank_ff[rd_idx_ff] == lru_rank)) begin
            vict_ok_ff  <= 1'b1;
            vict_idx_ff <= rd_idx_ff;
            vict_key_ff <= rd_key_ff;
         end
         if (!slot_valid && !free_ok_ff) begin
            free_ok_ff  <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
      end
   end

   // recency ranks: promoted slot to zero, the more recent ones back by one
   always_ff @(posedge clock) begin
      if ((state_ff == ST_UPD) && do_promote) begin
         for (int i = 0; i < N; i++) begin
            if (IDX_W'(i) == tgt_idx) begin
               rank_ff[i] <= '0;
            end else if (valid_ff[i] && (do_fill || (rank_ff[i] < old_rank))) begin
               rank_ff[i] <= rank_ff[i] + RANK_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else if ((state_ff == ST_UPD) && do_fill) begin
         valid_ff[tgt_idx] <= 1'b1;
         occ_ff            <= occ_ff + CNT_W'(1);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_UPD) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPD) begin
         rsp_hit_ff   <= found_ff;
         rsp_evict_ff <= do_evict;
         if (func_ff == lkvc_pkg::FUNC_PUT) begin
            rsp_rval_ff <= '0;
         end else if (found_ff) begin
            rsp_rval_ff <= found_val_ff;
         end else begin
            rsp_rval_ff <= '1;
         end
         rsp_ekey_ff  <= do_evict ? vict_key_ff : '0;
      end
   end

   // checks
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(occ_ff))
      else $error("occupancy count disagrees with valid bits");

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= 32'(N))
      else $error("occupancy above slot count");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while a response is pending");

   a_update_to_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |=> rsp_tvalid)
      else $error("update did not produce a response");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the LRU key-value cache: directed and random get/put traffic.
module tb;

   typedef struct packed {
      logic                        hit;
      logic [lkvc_pkg::DATA_W-1:0] read_value;
      logic                        evicted;
      logic [lkvc_pkg::DATA_W-1:0] evicted_key;
   } lookup_result_type;

   localparam int POOL_SIZE = 24;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic              req_tuser   = lkvc_pkg::FUNC_GET;
   logic [63:0]       req_tdata   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [1:0]        rsp_tuser;
   logic [63:0]       rsp_tdata;
   logic              csr_wr_en   = 1'b0;
   logic [lkvc_pkg::CAP_W-1:0] csr_wr_data = '0;

   // expected responses, oldest first
   lookup_result_type expected_results[$];
   int                mismatches  = 0;
   int                send_idle_pct = 0;
   int                recv_stall_pct = 0;
   logic [lkvc_pkg::DATA_W-1:0] key_pool[POOL_SIZE];

   // shadow copy of the cache contents
   logic [lkvc_pkg::DATA_W-1:0] shadow_key[lkvc_pkg::ENTRIES];
   logic [lkvc_pkg::DATA_W-1:0] shadow_value[lkvc_pkg::ENTRIES];
   bit                shadow_used[lkvc_pkg::ENTRIES];
   int unsigned       shadow_age[lkvc_pkg::ENTRIES];
   int unsigned       shadow_count;
   logic [lkvc_pkg::CAP_W-1:0] shadow_capacity;

   lru_key_value_cache dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Slot s becomes most recent; valid slots more recent than its old age shift back.
   function automatic void make_most_recent(int s, int unsigned old_age);
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (i != s && shadow_used[i] && shadow_age[i] < old_age)
            shadow_age[i] += 1;
      end
      shadow_age[s] = 0;
   endfunction

   // Applies one request to the shadow cache and returns the response it must produce.
   function automatic lookup_result_type cache_access(logic op,
                                                      logic [lkvc_pkg::DATA_W-1:0] k,
                                                      logic [lkvc_pkg::DATA_W-1:0] v);
      lookup_result_type r;
      int             slot;
      int             victim;
      int unsigned    oldest;
      int unsigned    limit;
      r = '0;
      slot = -1;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (slot < 0 && shadow_used[i] && shadow_key[i] == k)
            slot = i;
      end
      if (op == lkvc_pkg::FUNC_GET) begin
         if (slot >= 0) begin
            r.hit = 1'b1;
            r.read_value = shadow_value[slot];
            make_most_recent(slot, shadow_age[slot]);
         end else begin
            r.read_value = '1;
         end
         return r;
      end
      if (slot >= 0) begin
         shadow_value[slot] = v;
         make_most_recent(slot, shadow_age[slot]);
         r.hit = 1'b1;
         return r;
      end
      // zero capacity acts as one, anything past the slot count saturates
      limit = (shadow_capacity == 0) ? 1 :
              (shadow_capacity > lkvc_pkg::ENTRIES) ? lkvc_pkg::ENTRIES : shadow_capacity;
      if (shadow_count >= limit) begin
         victim = -1;
         oldest = 0;
         for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            if (shadow_used[i] && (victim < 0 || shadow_age[i] > oldest)) begin
               victim = i;
               oldest = shadow_age[i];
            end
         end
         if (victim >= 0) begin
            r.evicted = 1'b1;
            r.evicted_key = shadow_key[victim];
            shadow_key[victim] = k;
            shadow_value[victim] = v;
            make_most_recent(victim, oldest);
            return r;
         end
      end
      // fill the lowest free slot
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         if (!shadow_used[i]) begin
            shadow_used[i] = 1'b1;
            shadow_key[i] = k;
            shadow_value[i] = v;
            make_most_recent(i, 32'hFFFF_FFFF);
            shadow_count += 1;
            return r;
         end
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [lkvc_pkg::DATA_W-1:0] exp_val,
                                       logic [lkvc_pkg::DATA_W-1:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %h, got %h", name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   // Response checker and receiver back-pressure.
   always @(posedge clock) begin : response_check
      lookup_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_tuser[0]));
            check_field("evicted", 32'(want.evicted), 32'(rsp_tuser[1]));
            check_field("read_value", want.read_value, rsp_tdata[31:0]);
            check_field("evicted_key", want.evicted_key, rsp_tdata[63:32]);
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Offers one request (after a random idle gap) and records its expected response.
   // Valid is left high on return so back-to-back requests need no extra edge.
   task automatic send_request(logic op, logic [lkvc_pkg::DATA_W-1:0] k,
                               logic [lkvc_pkg::DATA_W-1:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {v, k};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(cache_access(op, k, v));
   endtask

   // Hold off new requests until every outstanding response is back.
   task automatic wait_for_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic write_capacity(logic [lkvc_pkg::CAP_W-1:0] cap);
      wait_for_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      shadow_capacity = cap;
      csr_wr_en   <= 1'b0;
   endtask

   // Empty cache: every get misses and reads back all ones.
   task automatic test_empty_lookups();
      send_request(lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
   endtask

   // Extreme keys and values stored and read back.
   task automatic test_extreme_keys();
      send_request(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'h7FFF_FFFF);
      send_request(lkvc_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h8000_0000);
      send_request(lkvc_pkg::FUNC_PUT, 32'h8000_0000, 32'h0000_0000);
      send_request(lkvc_pkg::FUNC_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_request(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(lkvc_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(lkvc_pkg::FUNC_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(lkvc_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000);
   endtask

   // Put on a present key overwrites in place.
   task automatic test_overwrite();
      send_request(lkvc_pkg::FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
      send_request(lkvc_pkg::FUNC_GET, 32'h0000_0000, 32'h0000_0000);
   endtask

   // Capacity dropped below occupancy: misses evict the oldest, occupancy holds.
   task automatic test_capacity_shrink();
      write_capacity(5'd1);
      send_request(lkvc_pkg::FUNC_PUT, 32'h0000_00A1, 32'h5555_5555);
      send_request(lkvc_pkg::FUNC_PUT, 32'h0000_00B2, 32'hAAAA_AAAA);
      send_request(lkvc_pkg::FUNC_GET, 32'h0000_00A1, 32'h0000_0000);
   endtask

   // Zero capacity behaves as one entry.
   task automatic test_capacity_zero();
      write_capacity(5'd0);
      send_request(lkvc_pkg::FUNC_PUT, 32'h0000_00C3, 32'h0F0F_0F0F);
      send_request(lkvc_pkg::FUNC_GET, 32'h0000_00B2, 32'h0000_0000);
   endtask

   // Capacity above the slot count saturates; misses fill free slots.
   task automatic test_capacity_saturate();
      write_capacity(5'd31);
      send_request(lkvc_pkg::FUNC_PUT, 32'h0000_00D4, 32'h0000_0001);
      send_request(lkvc_pkg::FUNC_PUT, 32'h0000_00E5, 32'h0000_0002);
      send_request(lkvc_pkg::FUNC_PUT, 32'h0000_00F6, 32'h0000_0003);
   endtask

   // Random gets and puts, mostly on a small key set so hits and evictions are frequent.
   task automatic test_random_phase(int count, logic [lkvc_pkg::CAP_W-1:0] cap, int idle_pct,
                                    int stall_pct, int keys_used);
      logic                        op;
      logic [lkvc_pkg::DATA_W-1:0] k;
      write_capacity(cap);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         op = 1'($urandom_range(1));
         if ($urandom_range(4) == 0)
            k = $urandom;
         else
            k = key_pool[$urandom_range(keys_used - 1)];
         send_request(op, k, $urandom);
         if ($urandom_range(49) == 0)
            wait_for_responses();
      end
   endtask

   initial begin
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
         shadow_used[i] = 1'b0;
         shadow_age[i]  = 0;
      end
      shadow_count    = 0;
      shadow_capacity = lkvc_pkg::CAP_W'(lkvc_pkg::CAP_RST);
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_empty_lookups();
      test_extreme_keys();
      test_overwrite();
      test_capacity_shrink();
      test_capacity_zero();
      test_capacity_saturate();
      test_random_phase(150, 5'd16, 0, 0, 24);
      test_random_phase(120, 5'd31, 76, 0, 24);
      test_random_phase(120, 5'd3, 0, 76, 6);
      test_random_phase(80, 5'd1, 26, 26, 3);
      test_random_phase(120, 5'd8, 26, 26, 12);
      test_random_phase(40, 5'd0, 0, 0, 3);
      test_random_phase(70, 5'd16, 76, 76, 20);

      wait_for_responses();
      repeat (lkvc_pkg::ENTRIES + 8) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
